/* rtl/core/ppsc_pkg.sv */
`timescale 1ns / 1ps

package ppsc_pkg;

  // Channel count and result budget per input item
  localparam int NUM_CHANNELS = 8;
  localparam int MAX_RES      = 16;
  localparam int PIN_N        = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
  localparam int CNT_W        = $clog2(MAX_RES + 1);

  // Field widths
  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int US_W   = 26;
  localparam int CH_W   = 4;
  localparam int PIN_W  = 8;

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 64;

  localparam logic [MS_W-1:0] DEFAULT_MS = MS_W'(50);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RATE = 2'd1,
    OP_CFG  = 2'd2
  } ppsc_op_e;

  typedef enum logic [2:0] {
    EV_START     = 3'd0,
    EV_PULSE_END = 3'd1,
    EV_CYCLE_END = 3'd2,
    EV_CMD_OK    = 3'd3,
    EV_CMD_BAD   = 3'd4,
    EV_CFG_OK    = 3'd5,
    EV_CFG_BAD   = 3'd6
  } ppsc_event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMD,
    ST_FLUSH
  } ppsc_state_e;

  // Captured input item
  typedef struct packed {
    ppsc_op_e          op;
    logic [TIME_W-1:0] now;
    logic [CH_W-1:0]   ch;
    logic [MS_W-1:0]   rate;
    logic [MS_W-1:0]   pulse;
    logic              pg;
    logic [MS_W-1:0]   rec;
    logic              rg;
  } ppsc_item_t;

  // Sequencer to cell row
  typedef struct packed {
    logic       tok_start;
    logic       shift;
    logic       clear;
    logic       commit;
    logic       cmd_sel;
    logic       cmd_we;
    ppsc_item_t itm;
  } ppsc_ctrl_t;

  // Per-cell status, event flags and rate masked by selection
  typedef struct packed {
    logic            tok;
    logic            ev_start;
    logic            ev_pend;
    logic            ev_cend;
    logic            cmd_bad;
    logic            pin_nxt;
    logic [MS_W-1:0] rate;
  } ppsc_cell_out_t;

  // Row summary back to the sequencer
  typedef struct packed {
    logic             tok_last;
    logic             ev_start;
    logic             ev_pend;
    logic             ev_cend;
    logic             cmd_bad;
    logic [CH_W-1:0]  chan;
    logic [MS_W-1:0]  rate;
    logic [PIN_W-1:0] pin_mask;
  } ppsc_sum_t;

  typedef struct packed {
    ppsc_event_e       code;
    logic [CH_W-1:0]   chan;
    logic [MS_W-1:0]   rate;
    logic [TIME_W-1:0] time_us;
    logic [PIN_W-1:0]  pin;
  } ppsc_event_t;

  // Milliseconds to microseconds: x*1000 = x*1024 - x*16 - x*8
  function automatic logic [US_W-1:0] ms_to_us(logic [MS_W-1:0] ms);
    return {ms, 10'b0} - {6'b0, ms, 4'b0} - {7'b0, ms, 3'b0};
  endfunction

endpackage

/* rtl/core/ppsc_cell.sv */
`timescale 1ns / 1ps

module ppsc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ppsc_pkg::ppsc_ctrl_t    ctrl_i,
  input  logic                    tok_i,
  input  logic                    hit_i,
  output ppsc_pkg::ppsc_cell_out_t stat_o
);
  import ppsc_pkg::*;

  logic              tok_q, tok_d;
  logic              active_q, active_d;
  logic              pin_q, pin_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [MS_W-1:0]   rate_q, rate_d;
  logic [MS_W-1:0]   pulse_q, pulse_d;
  logic [MS_W-1:0]   rec_q, rec_d;
  logic [US_W-1:0]   rate_us_q, rate_us_d;
  logic [US_W-1:0]   pulse_us_q, pulse_us_d;

  logic [TIME_W-1:0] elapsed;
  logic              rate_reached;
  logic              pulse_reached;
  logic              ev_start;
  logic              ev_pend;
  logic              ev_cend;
  logic              rate_bad;
  logic              pin_new;
  logic              tick_upd;
  logic              cmd_upd;

  // Wrap-safe elapsed time since cycle start
  assign elapsed       = ctrl_i.itm.now - start_q;
  assign rate_reached  = !elapsed[TIME_W-1] && (elapsed >= {6'b0, rate_us_q});
  assign pulse_reached = !elapsed[TIME_W-1] && (elapsed >= {6'b0, pulse_us_q});

  // Evaluate this channel for the current tick
  assign ev_start = !active_q && (rate_q != '0);
  assign ev_cend  = active_q && (rate_q != '0) && rate_reached;
  assign ev_pend  = active_q && pin_q && (ev_cend || pulse_reached);

  // Rate must cover pulse plus recovery unless it stops the channel
  assign rate_bad = (ctrl_i.itm.rate != '0) &&
                    ({1'b0, ctrl_i.itm.rate} < ({1'b0, pulse_q} + {1'b0, rec_q}));

  assign tick_upd = ctrl_i.commit && tok_q;
  assign cmd_upd  = ctrl_i.cmd_we && hit_i;
  assign pin_new  = ev_start ? 1'b1 : (ev_pend ? 1'b0 : pin_q);

  // Token chain: take the neighbor's token on each shift
  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.clear) begin
      tok_d = 1'b0;
    end else if (ctrl_i.shift) begin
      tok_d = tok_i;
    end
  end

  // Channel state update
  always_comb begin
    active_d   = active_q;
    pin_d      = pin_q;
    start_d    = start_q;
    rate_d     = rate_q;
    pulse_d    = pulse_q;
    rec_d      = rec_q;
    rate_us_d  = rate_us_q;
    pulse_us_d = pulse_us_q;
    if (tick_upd) begin
      pin_d = pin_new;
      if (ev_start) begin
        active_d = 1'b1;
        start_d  = ctrl_i.itm.now;
      end else if (ev_cend) begin
        active_d = 1'b0;
      end
    end
    if (cmd_upd) begin
      case (ctrl_i.itm.op)
        OP_RATE: begin
          if (!rate_bad) begin
            rate_d    = ctrl_i.itm.rate;
            rate_us_d = ms_to_us(ctrl_i.itm.rate);
          end
        end
        OP_CFG: begin
          if (ctrl_i.itm.pg && (ctrl_i.itm.pulse != '0)) begin
            pulse_d    = ctrl_i.itm.pulse;
            pulse_us_d = ms_to_us(ctrl_i.itm.pulse);
          end
          if (ctrl_i.itm.rg) begin
            rec_d = ctrl_i.itm.rec;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q      <= 1'b0;
      active_q   <= 1'b0;
      pin_q      <= 1'b0;
      start_q    <= '0;
      rate_q     <= '0;
      pulse_q    <= DEFAULT_MS;
      rec_q      <= DEFAULT_MS;
      rate_us_q  <= '0;
      pulse_us_q <= ms_to_us(DEFAULT_MS);
    end else begin
      tok_q      <= tok_d;
      active_q   <= active_d;
      pin_q      <= pin_d;
      start_q    <= start_d;
      rate_q     <= rate_d;
      pulse_q    <= pulse_d;
      rec_q      <= rec_d;
      rate_us_q  <= rate_us_d;
      pulse_us_q <= pulse_us_d;
    end
  end

  // Status, masked so the row can be OR-reduced
  always_comb begin
    stat_o.tok      = tok_q;
    stat_o.ev_start = tok_q && ev_start;
    stat_o.ev_pend  = tok_q && ev_pend;
    stat_o.ev_cend  = tok_q && ev_cend;
    stat_o.cmd_bad  = hit_i && rate_bad;
    stat_o.pin_nxt  = tick_upd ? pin_new : pin_q;
    stat_o.rate     = (tok_q || hit_i) ? rate_q : '0;
  end

endmodule

/* rtl/core/ppsc_seq.sv */
`timescale 1ns / 1ps

module ppsc_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [ppsc_pkg::S_TDATA_W-1:0]       s_axis_tdata_i,
  input  logic [1:0]                           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [ppsc_pkg::M_TDATA_W-1:0]       m_axis_tdata_o,
  output logic [2:0]                           m_axis_tuser_o,
  output logic                                 m_axis_tlast_o,
  input  ppsc_pkg::ppsc_sum_t                  sum_i,
  output ppsc_pkg::ppsc_ctrl_t                 ctrl_o
);
  import ppsc_pkg::*;

  ppsc_state_e state_q, state_d;
  ppsc_item_t  itm_q;
  ppsc_item_t  itm_in;
  logic        second_q, second_d;
  logic [CNT_W-1:0] cnt_q;
  logic        hold_vld_q;
  ppsc_event_t hold_q;
  ppsc_event_t out_q;
  ppsc_event_t ev_new;
  logic        m_vld_q;
  logic        last_q;

  logic        accept;
  logic        out_free;
  logic        hold_ok;
  logic        budget_hit;
  logic        any_ev;
  logic        in_range;
  logic        adv;
  logic        scan_done;
  logic        ev_emit;
  ppsc_event_e ev_code;
  logic        flush_push;
  logic        out_load;

  // Unpack the input transfer
  always_comb begin
    itm_in.op    = ppsc_op_e'(s_axis_tuser_i);
    itm_in.now   = s_axis_tdata_i[31:0];
    itm_in.ch    = s_axis_tdata_i[35:32];
    itm_in.rate  = s_axis_tdata_i[51:36];
    itm_in.pulse = s_axis_tdata_i[67:52];
    itm_in.pg    = s_axis_tdata_i[68];
    itm_in.rec   = s_axis_tdata_i[84:69];
    itm_in.rg    = s_axis_tdata_i[85];
  end

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !m_vld_q || m_axis_tready_i;
  assign hold_ok    = !hold_vld_q || out_free;
  assign budget_hit = ((CNT_W+1)'(cnt_q) + (CNT_W+1)'(2)) > (CNT_W+1)'(MAX_RES);
  assign any_ev     = sum_i.ev_start || sum_i.ev_pend || sum_i.ev_cend;
  assign in_range   = {1'b0, itm_q.ch} < (CH_W+1)'(NUM_CHANNELS);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (itm_in.op)
            OP_TICK: state_d = ST_SCAN;
            OP_RATE,
            OP_CFG:  state_d = ST_CMD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN:  if (scan_done) state_d = ST_FLUSH;
      ST_CMD:   state_d = ST_FLUSH;
      ST_FLUSH: if (!hold_vld_q || out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ctrl_o.tok_start = 1'b0;
    ctrl_o.clear     = 1'b0;
    ctrl_o.commit    = 1'b0;
    ctrl_o.cmd_sel   = 1'b0;
    ctrl_o.cmd_we    = 1'b0;
    adv        = 1'b0;
    ev_emit    = 1'b0;
    ev_code    = EV_START;
    second_d   = second_q;
    flush_push = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o  = 1'b1;
        ctrl_o.tok_start = accept && (itm_in.op == OP_TICK);
      end
      ST_SCAN: begin
        if (second_q) begin
          if (hold_ok) begin
            ev_emit  = 1'b1;
            ev_code  = EV_CYCLE_END;
            second_d = 1'b0;
            adv      = 1'b1;
          end
        end else if (budget_hit) begin
          ctrl_o.clear = 1'b1;
        end else if (!any_ev) begin
          adv = 1'b1;
        end else if (hold_ok) begin
          ctrl_o.commit = 1'b1;
          ev_emit       = 1'b1;
          if (sum_i.ev_start) begin
            ev_code = EV_START;
          end else if (sum_i.ev_pend) begin
            ev_code = EV_PULSE_END;
          end else begin
            ev_code = EV_CYCLE_END;
          end
          if (sum_i.ev_pend && sum_i.ev_cend) begin
            second_d = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
      end
      ST_CMD: begin
        ctrl_o.cmd_sel = 1'b1;
        ctrl_o.cmd_we  = 1'b1;
        ev_emit        = 1'b1;
        if (itm_q.op == OP_RATE) begin
          ev_code = (in_range && !sum_i.cmd_bad) ? EV_CMD_OK : EV_CMD_BAD;
        end else begin
          ev_code = in_range ? EV_CFG_OK : EV_CFG_BAD;
        end
      end
      ST_FLUSH: begin
        flush_push = hold_vld_q && out_free;
      end
      default: ;
    endcase
    ctrl_o.shift = ctrl_o.tok_start || adv;
    ctrl_o.itm   = itm_q;
  end

  assign scan_done = ctrl_o.clear || (adv && sum_i.tok_last);

  // Assemble the new event; pins already reflect this event
  always_comb begin
    ev_new.code    = ev_code;
    ev_new.time_us = itm_q.now;
    ev_new.pin     = sum_i.pin_mask;
    if (state_q == ST_CMD) begin
      ev_new.chan = itm_q.ch;
      ev_new.rate = (ev_code == EV_CMD_OK) ? itm_q.rate : sum_i.rate;
    end else begin
      ev_new.chan = sum_i.chan;
      ev_new.rate = sum_i.rate;
    end
  end

  assign out_load = (ev_emit && hold_vld_q) || flush_push;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      second_q   <= 1'b0;
      cnt_q      <= '0;
      hold_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (ev_emit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (ev_emit) begin
        hold_vld_q <= 1'b1;
      end else if (flush_push) begin
        hold_vld_q <= 1'b0;
      end
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: item capture, hold slot, output stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      itm_q <= itm_in;
    end
    if (ev_emit) begin
      hold_q <= ev_new;
    end
    if (out_load) begin
      out_q  <= hold_q;
      last_q <= flush_push;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tuser_o  = out_q.code;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {4'b0, out_q.pin, out_q.time_us, out_q.rate, out_q.chan};

  // The pending cycle end only exists mid-scan
  a_second_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (state_q == ST_SCAN))
    else $error("pending cycle end outside scan");

  // The hold slot is empty whenever the sequencer idles: an item's last result has moved to the output stage
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_vld_q)
    else $error("hold slot occupied while idle");

  // Pushing the hold slot never overwrites an untaken result
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output stage overwritten");

  // Result count stays within budget
  a_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W+1)'(cnt_q) <= (CNT_W+1)'(MAX_RES))
    else $error("result budget exceeded");

endmodule

/* rtl/core/pump_pulse_scheduler_core.sv */
`timescale 1ns / 1ps
// Flow: a command or configuration transfer is captured, evaluated into the hold slot and then
// moved to the output stage as its one result. No new item is accepted until the last is done;
// a tick walks the scan token down the cell row one channel at a time, takes an extra step for
// a channel whose pulse and cycle end together, and stalls while the output is held off.
// Reset: rst_ni async active low; all channels idle with pins low, rate 0, pulse and
// recovery 50 ms; no result pending.

module pump_pulse_scheduler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // now_us, channel, new_rate_ms, new_pulse_ms, pulse_given, new_recovery_ms,
  // recovery_given, zero pad
  input  logic [ppsc_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // opcode
  input  logic [1:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // event_channel, event_rate_ms, event_time_us, pin_mask, zero pad
  output logic [ppsc_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // event_res
  output logic [2:0]                     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import ppsc_pkg::*;

  ppsc_ctrl_t     ctrl;
  ppsc_sum_t      sum;
  ppsc_cell_out_t cell_stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] tok_in;
  logic [NUM_CHANNELS-1:0] hit;
  logic [NUM_CHANNELS-1:0] tok_vec;

  ppsc_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .sum_i           (sum),
    .ctrl_o          (ctrl)
  );

  // Row of channel cells; the scan token walks from channel 0 upward
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_in[g] = ctrl.tok_start;
    end else begin : g_link
      assign tok_in[g] = cell_stat[g-1].tok;
    end
    assign hit[g]     = ctrl.cmd_sel && (ctrl.itm.ch == CH_W'(g));
    assign tok_vec[g] = cell_stat[g].tok;

    ppsc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .tok_i  (tok_in[g]),
      .hit_i  (hit[g]),
      .stat_o (cell_stat[g])
    );
  end

  // Reduce the row status for the sequencer
  always_comb begin
    sum          = '0;
    sum.tok_last = cell_stat[NUM_CHANNELS-1].tok;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sum.ev_start = sum.ev_start | cell_stat[i].ev_start;
      sum.ev_pend  = sum.ev_pend  | cell_stat[i].ev_pend;
      sum.ev_cend  = sum.ev_cend  | cell_stat[i].ev_cend;
      sum.cmd_bad  = sum.cmd_bad  | cell_stat[i].cmd_bad;
      sum.rate     = sum.rate     | cell_stat[i].rate;
      if (cell_stat[i].tok) begin
        sum.chan = sum.chan | CH_W'(i);
      end
    end
    for (int i = 0; i < PIN_N; i++) begin
      sum.pin_mask[i] = cell_stat[i].pin_nxt;
    end
  end

  // At most one channel holds the scan token
  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("scan token duplicated");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

// Pump pulse scheduler core: streams ticks, rate commands and channel configs into the
// block. An in-bench scheduler tracks every channel's cycle, pulse and pin and predicts
// each event. Results are compared field by field against the oldest predicted event.
// Both sides idle at random. One phase holds the output off long enough to stall the
// input, and one waits for all events to drain.

module tb;
  import ppsc_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         RANDOM_ITEMS   = 280;
  localparam int         RX_HOLD_CYCLES = 300;
  localparam int         SETTLE_CYCLES  = 64;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_us;
    logic [3:0]  ch;
    logic [15:0] rate;
    logic [15:0] pulse;
    logic        pg;
    logic [15:0] rec;
    logic        rg;
  } pump_item_t;

  typedef struct packed {
    ppsc_event_e code;
    logic [3:0]  ch;
    logic [15:0] rate;
    logic [31:0] stamp_us;
    logic [7:0]  pins;
    logic        last;
  } pump_event_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic [1:0]           s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [2:0]           m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // Scheduler state tracked by the bench
  logic        chan_active  [NUM_CHANNELS];
  logic        pin_state    [NUM_CHANNELS];
  logic [31:0] cyc_start_us [NUM_CHANNELS];
  logic [15:0] rate_store   [NUM_CHANNELS];
  logic [15:0] pulse_store  [NUM_CHANNELS];
  logic [15:0] recov_store  [NUM_CHANNELS];

  pump_event_t pump_events_q[$];
  pump_event_t item_events [MAX_RES];
  int          item_event_n;

  logic [31:0] pump_now_us;
  bit          idle_enable;
  int          rx_hold_seq;
  int          mismatch_count;
  int          results_seen;
  int          event_seen [8];
  int          tick_count, rate_count, cfg_count, ignored_count;

  pump_pulse_scheduler_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Scheduler prediction
  // ---------------------------------------------------------------------------
  function automatic void reset_scheduler();
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_active[i]  = 1'b0;
      pin_state[i]    = 1'b0;
      cyc_start_us[i] = '0;
      rate_store[i]   = '0;
      pulse_store[i]  = 16'd50;
      recov_store[i]  = 16'd50;
    end
  endfunction

  function automatic logic [7:0] pin_levels();
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < NUM_CHANNELS && i < 8; i++)
      if (pin_state[i]) m[i] = 1'b1;
    return m;
  endfunction

  // Wrap-safe: a difference of half the time range or more is still in the future
  function automatic logic time_reached(logic [31:0] now, logic [31:0] start,
                                        logic [15:0] ms);
    logic [31:0] d;
    d = now - start;
    return (d < 32'h8000_0000) && (d >= 32'(ms) * 32'd1000);
  endfunction

  function automatic void note_event(ppsc_event_e code, logic [3:0] ch, logic [31:0] stamp);
    pump_event_t e;
    e.code     = code;
    e.ch       = ch;
    e.rate     = '0;
    if (int'(ch) < NUM_CHANNELS) e.rate = rate_store[int'(ch)];
    e.stamp_us = stamp;
    e.pins     = pin_levels();
    e.last     = 1'b0;
    item_events[item_event_n] = e;
    item_event_n++;
  endfunction

  function automatic void predict_pump_events(pump_item_t it);
    logic ok;
    logic cyc_end;
    int   c;
    item_event_n = 0;
    c = int'(it.ch);
    case (it.op)
      OP_TICK: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (item_event_n + 2 > MAX_RES) break;
          if (!chan_active[i]) begin
            if (rate_store[i] != 0) begin
              chan_active[i]  = 1'b1;
              pin_state[i]    = 1'b1;
              cyc_start_us[i] = it.now_us;
              note_event(EV_START, 4'(i), it.now_us);
            end
          end else begin
            cyc_end = (rate_store[i] != 0) &&
                      time_reached(it.now_us, cyc_start_us[i], rate_store[i]);
            // a cycle end with the pin still high reports the pulse end first
            if (pin_state[i] &&
                (cyc_end || time_reached(it.now_us, cyc_start_us[i], pulse_store[i]))) begin
              pin_state[i] = 1'b0;
              note_event(EV_PULSE_END, 4'(i), it.now_us);
            end
            if (cyc_end) begin
              chan_active[i] = 1'b0;
              note_event(EV_CYCLE_END, 4'(i), it.now_us);
            end
          end
        end
      end
      OP_RATE: begin
        ok = c < NUM_CHANNELS;
        if (ok && it.rate != 0 &&
            int'(it.rate) < int'(pulse_store[c]) + int'(recov_store[c]))
          ok = 1'b0;
        if (ok) begin
          rate_store[c] = it.rate;
          note_event(EV_CMD_OK, it.ch, it.now_us);
        end else begin
          note_event(EV_CMD_BAD, it.ch, it.now_us);
        end
      end
      OP_CFG: begin
        if (c < NUM_CHANNELS) begin
          // a zero pulse leaves the stored pulse alone
          if (it.pg && it.pulse != 0) pulse_store[c] = it.pulse;
          if (it.rg) recov_store[c] = it.rec;
          note_event(EV_CFG_OK, it.ch, it.now_us);
        end else begin
          note_event(EV_CFG_BAD, it.ch, it.now_us);
        end
      end
      default: ;
    endcase
    if (item_event_n > 0) item_events[item_event_n-1].last = 1'b1;
    for (int i = 0; i < item_event_n; i++) pump_events_q.push_back(item_events[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic pump_item_t random_item();
    pump_item_t it;
    it.op     = 2'($urandom_range(0, 3));
    it.now_us = $urandom();
    it.ch     = 4'($urandom_range(0, 15));
    it.rate   = 16'($urandom());
    it.pulse  = 16'($urandom());
    it.pg     = 1'($urandom());
    it.rec    = 16'($urandom());
    it.rg     = 1'($urandom());
    return it;
  endfunction

  task automatic send_item(pump_item_t it);
    int gap;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, it.rg, it.rec, it.pg, it.pulse, it.rate, it.ch, it.now_us};
    s_axis_tuser_i  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_pump_events(it);
    case (it.op)
      OP_TICK: tick_count++;
      OP_RATE: rate_count++;
      OP_CFG:  cfg_count++;
      default: ignored_count++;
    endcase
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic send_tick(logic [31:0] step_us);
    pump_item_t it;
    it = random_item();
    pump_now_us = pump_now_us + step_us;
    it.op     = OP_TICK;
    it.now_us = pump_now_us;
    send_item(it);
  endtask

  task automatic send_rate(int ch, int rate);
    pump_item_t it;
    it = random_item();
    it.op     = OP_RATE;
    it.now_us = pump_now_us;
    it.ch     = 4'(ch);
    it.rate   = 16'(rate);
    send_item(it);
  endtask

  task automatic send_cfg(int ch, int pulse, bit pg, int rec, bit rg);
    pump_item_t it;
    it = random_item();
    it.op     = OP_CFG;
    it.now_us = pump_now_us;
    it.ch     = 4'(ch);
    it.pulse  = 16'(pulse);
    it.pg     = pg;
    it.rec    = 16'(rec);
    it.rg     = rg;
    send_item(it);
  endtask

  task automatic wait_for_results();
    while (pump_events_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin : sink_side
    int stall_left;
    int hold_left;
    int hold_seen;
    m_axis_tready_i = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_seq != hold_seen) begin
        hold_seen = rx_hold_seq;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (stall_left == 0 && idle_enable && $urandom_range(0, 99) < 25)
          stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  // Compare one field and log a mismatch
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Check each result transfer against the oldest predicted event
  always @(posedge clk_i) begin : result_check
    pump_event_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      event_seen[m_axis_tuser_o]++;
      if (pump_events_q.size() == 0) begin
        $display("%0t ns: unexpected result, event %0d channel %0d", $time,
                 m_axis_tuser_o, m_axis_tdata_o[3:0]);
        mismatch_count++;
      end else begin
        want = pump_events_q.pop_front();
        check_field("event", 32'(want.code), 32'(m_axis_tuser_o));
        check_field("channel", 32'(want.ch), 32'(m_axis_tdata_o[3:0]));
        check_field("rate_ms", 32'(want.rate), 32'(m_axis_tdata_o[19:4]));
        check_field("time_us", want.stamp_us, m_axis_tdata_o[51:20]);
        check_field("pin_mask", 32'(want.pins), 32'(m_axis_tdata_o[59:52]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Boundaries, rejects, wrap of the time counter, rate zero mid-cycle
  task automatic test_directed_cases();
    pump_item_t it;
    logic [31:0] base_us;
    base_us     = 32'hFFFF_F830;
    pump_now_us = base_us;
    send_tick(0);                        // nothing running yet
    it = random_item();
    it.op = OP_UNUSED;
    send_item(it);                       // ignored opcode
    send_cfg(15, 65535, 1, 65535, 1);    // channel out of range
    send_cfg(15, 0, 0, 0, 0);
    send_rate(8, 100);                   // first channel past the end
    send_cfg(0, 0, 1, 2, 1);             // zero pulse keeps 50 ms
    send_rate(0, 51);                    // one below pulse plus recovery
    send_rate(0, 52);                    // exactly pulse plus recovery
    send_cfg(1, 65535, 1, 65535, 1);
    send_rate(1, 65535);                 // below the summed maximum
    send_cfg(1, 3, 1, 0, 1);
    send_rate(1, 3);                     // pulse fills the whole cycle
    send_cfg(7, 9, 0, 0, 0);             // nothing given
    send_rate(5, 0);
    send_tick(0);                        // channels 0 and 1 start
    send_tick(3000);                     // wraps past zero; channel 1 ends with pin high
    send_rate(0, 0);                     // stop channel 0 mid-cycle
    pump_now_us = base_us;
    send_tick(50000);                    // channel 0 pulse ends, stays active
    pump_now_us = base_us;
    send_tick(40000);                    // time steps back: nothing reached
    send_rate(0, 60);
    pump_now_us = base_us;
    send_tick(110000);                   // channel 0 cycle end with pin low
    send_tick(0);                        // both restart
  endtask

  // Well-formed schedules with random content, plus noise
  task automatic test_random_traffic();
    pump_item_t it;
    int counted;
    int ch;
    int sum;
    int r;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      idle_enable = ($urandom_range(0, 4) != 0);
      // reconfigure a few channels with short times
      repeat ($urandom_range(1, 4)) begin
        send_cfg($urandom_range(0, NUM_CHANNELS - 1), $urandom_range(0, 8),
                 $urandom_range(0, 5) != 0, $urandom_range(0, 6), $urandom_range(0, 5) != 0);
        counted++;
      end
      // set rates, mostly legal
      repeat ($urandom_range(1, 4)) begin
        ch  = $urandom_range(0, NUM_CHANNELS - 1);
        sum = int'(pulse_store[ch]) + int'(recov_store[ch]);
        r   = $urandom_range(0, 9);
        if (r < 6) begin
          sum = sum + $urandom_range(0, 12);
          send_rate(ch, (sum > 65535) ? 65535 : sum);
        end else if (r < 8) begin
          send_rate(ch, 0);
        end else begin
          send_rate(ch, (sum > 1) ? $urandom_range(1, sum - 1) : 1);
        end
        counted++;
      end
      // advance time
      repeat ($urandom_range(6, 24)) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          it = random_item();
          if (it.op == OP_TICK) pump_now_us = it.now_us;
          send_item(it);
          if (it.op != OP_UNUSED) counted++;
        end else begin
          counted++;
          if (r < 80)      send_tick($urandom_range(200, 2500));
          else if (r < 88) send_tick(0);
          else if (r < 94) send_tick(32'd0 - 32'($urandom_range(1, 5000)));
          else             send_tick($urandom());
        end
      end
    end
    idle_enable = 1'b1;
  endtask

  // Every channel ends its cycle with the pin high; the output holds off meanwhile
  task automatic test_output_backpressure();
    idle_enable = 1'b0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      send_cfg(ch, 2, 1, 0, 1);
      send_rate(ch, 2);
    end
    rx_hold_seq++;
    repeat (20) send_tick(2000);
    idle_enable = 1'b1;
  endtask

  // Sender pauses until every predicted event has come out
  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(3, 8)) send_tick($urandom_range(500, 3000));
      hold_input();
      wait_for_results();
    end
    send_rate($urandom_range(0, NUM_CHANNELS - 1), 0);
  endtask

  // Give up after a generous time
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    idle_enable     = 1'b1;
    rx_hold_seq     = 0;
    mismatch_count  = 0;
    results_seen    = 0;
    tick_count      = 0;
    rate_count      = 0;
    cfg_count       = 0;
    ignored_count   = 0;
    pump_now_us     = '0;
    for (int i = 0; i < 8; i++) event_seen[i] = 0;
    reset_scheduler();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();

    // drain, then allow stray results to show up
    hold_input();
    idle_enable = 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d ticks, %0d rate commands, %0d channel configs, %0d ignored items",
             tick_count, rate_count, cfg_count, ignored_count);
    $display("Checked %0d results: %0d starts, %0d pulse ends, %0d cycle ends, %0d rejects",
             results_seen, event_seen[EV_START], event_seen[EV_PULSE_END],
             event_seen[EV_CYCLE_END], event_seen[EV_CMD_BAD] + event_seen[EV_CFG_BAD]);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ppsc_pkg.sv
rtl/core/ppsc_cell.sv
rtl/core/ppsc_seq.sv
rtl/core/pump_pulse_scheduler_core.sv
verif/tb.sv
